@@ hdl/ssi_pkg.sv @@
package ssi_pkg;

   localparam int CoordWidth  = 16;
   localparam int RadiusWidth = 15;
   // Differences of two coordinates need one extra bit.
   localparam int DiffWidth   = CoordWidth + 1;
   localparam int SquareWidth = 2 * CoordWidth;
   localparam int CrossWidth  = SquareWidth + 1;
   localparam int RadSqWidth  = 2 * RadiusWidth;
   // A sum of three squares stays below 2^34.
   localparam int LenWidth    = SquareWidth + 2;
   localparam int DotWidth    = LenWidth + 1;
   localparam int HalfWidth   = LenWidth / 2;
   localparam int PartWidth   = 2 * HalfWidth;
   localparam int ProdWidth   = 2 * LenWidth;

   typedef logic signed [DiffWidth-1:0]  diff_type;
   typedef logic [PartWidth-1:0]         part_type;
   typedef logic [ProdWidth-1:0]         prod_type;

   // Quadratic coefficients of one word, handed from the dot-product stages
   // to the decision stages.
   typedef struct packed {
      logic                        valid;
      logic [LenWidth-1:0]         len_sq;
      logic signed [DotWidth-1:0]  neg_h;
      logic signed [DotWidth-1:0]  f0;
      logic signed [DotWidth-1:0]  f1;
   } dot_type;

endpackage

@@ hdl/segment_sphere_intersect.sv @@
// Segment against sphere surface test. Each word on the req_ ports is one
// segment (start, end) and one sphere (center, radius) in a shared signed
// fixed-point scale; the decision is exact. The block takes a new word in
// every clock cycle (busy is always low) and returns exactly one result word
// per accepted word, in order, marked by rsp_strobe for one cycle. The
// receiver cannot stall: a result must be taken in the cycle it is shown.
// The pipeline has six register stages: differences, per-axis products,
// axis sums, partial products of the 68-bit discriminant terms, product
// assembly, and the final compare. rsp_hit reports a crossing of the
// sphere surface for some t in [0,1]; rsp_degenerate marks a zero-length
// segment, which never hits.
module segment_sphere_intersect (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   req_start_x,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   req_start_y,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   req_start_z,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   req_end_x,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   req_end_y,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   req_end_z,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   req_center_x,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   req_center_y,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   req_center_z,
   input  logic [ssi_pkg::RadiusWidth-1:0]         req_sphere_radius,
   output logic                                    rsp_strobe,
   output logic                                    rsp_hit,
   output logic                                    rsp_degenerate
);

   ssi_pkg::dot_type dot;
   logic             accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   ssi_dot u_dot (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .start_x       (req_start_x),
      .start_y       (req_start_y),
      .start_z       (req_start_z),
      .end_x         (req_end_x),
      .end_y         (req_end_y),
      .end_z         (req_end_z),
      .center_x      (req_center_x),
      .center_y      (req_center_y),
      .center_z      (req_center_z),
      .sphere_radius (req_sphere_radius),
      .dot           (dot)
   );

   ssi_decide u_decide (
      .clock      (clock),
      .reset      (reset),
      .dot        (dot),
      .strobe     (rsp_strobe),
      .hit        (rsp_hit),
      .degenerate (rsp_degenerate)
   );

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_strobe)
      else $error("accepted word did not produce a result after six cycles");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 6))
      else $error("result word without a matching accepted word");

   a_degen_no_hit : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |-> !rsp_hit)
      else $error("zero-length segment reported a hit");

   a_reset_clears : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe set right after reset");

endmodule

@@ hdl/ssi_dot.sv @@
module ssi_dot (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   start_x,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   start_y,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   start_z,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   end_x,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   end_y,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   end_z,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   center_x,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   center_y,
   input  logic signed [ssi_pkg::CoordWidth-1:0]   center_z,
   input  logic [ssi_pkg::RadiusWidth-1:0]         sphere_radius,
   output ssi_pkg::dot_type                        dot
);

   logic signed [ssi_pkg::CoordWidth-1:0] p0 [3];
   logic signed [ssi_pkg::CoordWidth-1:0] p1 [3];
   logic signed [ssi_pkg::CoordWidth-1:0] cc [3];

   // Stage 1: coordinate differences.
   logic                  s1_valid_ff;
   ssi_pkg::diff_type     v1_in [3];
   ssi_pkg::diff_type     v2_in [3];
   ssi_pkg::diff_type     w_in  [3];
   ssi_pkg::diff_type     v1_ff [3];
   ssi_pkg::diff_type     v2_ff [3];
   ssi_pkg::diff_type     w_ff  [3];
   logic [ssi_pkg::RadiusWidth-1:0] r_ff;

   // Stage 2: per-axis products.
   logic                                   s2_valid_ff;
   logic signed [2*ssi_pkg::DiffWidth-1:0] a_prod [3];
   logic signed [2*ssi_pkg::DiffWidth-1:0] h_prod [3];
   logic signed [2*ssi_pkg::DiffWidth-1:0] d0_prod [3];
   logic signed [2*ssi_pkg::DiffWidth-1:0] d1_prod [3];
   logic [ssi_pkg::SquareWidth-1:0]        a_term_ff  [3];
   logic signed [ssi_pkg::CrossWidth-1:0]  h_term_ff  [3];
   logic [ssi_pkg::SquareWidth-1:0]        d0_term_ff [3];
   logic [ssi_pkg::SquareWidth-1:0]        d1_term_ff [3];
   logic [ssi_pkg::RadSqWidth-1:0]         rr_ff;

   // Stage 3: sums over the three axes.
   logic                                   s3_valid_ff;
   logic [ssi_pkg::LenWidth-1:0]           len_sq_in, len_sq_ff;
   logic signed [ssi_pkg::DotWidth-1:0]    h_sum;
   logic signed [ssi_pkg::DotWidth-1:0]    neg_h_in, neg_h_ff;
   logic [ssi_pkg::LenWidth-1:0]           d0_sum, d1_sum;
   logic signed [ssi_pkg::DotWidth-1:0]    rr_ext;
   logic signed [ssi_pkg::DotWidth-1:0]    f0_in, f0_ff, f1_in, f1_ff;

   assign p0[0] = start_x;  assign p0[1] = start_y;  assign p0[2] = start_z;
   assign p1[0] = end_x;    assign p1[1] = end_y;    assign p1[2] = end_z;
   assign cc[0] = center_x; assign cc[1] = center_y; assign cc[2] = center_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v1_in[i] = ssi_pkg::diff_type'(p0[i]) - ssi_pkg::diff_type'(cc[i]);
         v2_in[i] = ssi_pkg::diff_type'(p1[i]) - ssi_pkg::diff_type'(p0[i]);
         w_in[i]  = ssi_pkg::diff_type'(p1[i]) - ssi_pkg::diff_type'(cc[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_prod[i]  = v2_ff[i] * v2_ff[i];
         h_prod[i]  = v1_ff[i] * v2_ff[i];
         d0_prod[i] = v1_ff[i] * v1_ff[i];
         d1_prod[i] = w_ff[i] * w_ff[i];
      end
   end

   always_comb begin
      len_sq_in = ssi_pkg::LenWidth'(a_term_ff[0]) + ssi_pkg::LenWidth'(a_term_ff[1])
                + ssi_pkg::LenWidth'(a_term_ff[2]);
      h_sum     = ssi_pkg::DotWidth'(h_term_ff[0]) + ssi_pkg::DotWidth'(h_term_ff[1])
                + ssi_pkg::DotWidth'(h_term_ff[2]);
      neg_h_in  = -h_sum;
      d0_sum    = ssi_pkg::LenWidth'(d0_term_ff[0]) + ssi_pkg::LenWidth'(d0_term_ff[1])
                + ssi_pkg::LenWidth'(d0_term_ff[2]);
      d1_sum    = ssi_pkg::LenWidth'(d1_term_ff[0]) + ssi_pkg::LenWidth'(d1_term_ff[1])
                + ssi_pkg::LenWidth'(d1_term_ff[2]);
      rr_ext    = $signed({{(ssi_pkg::DotWidth-ssi_pkg::RadSqWidth){1'b0}}, rr_ff});
      f0_in     = $signed({1'b0, d0_sum}) - rr_ext;
      f1_in     = $signed({1'b0, d1_sum}) - rr_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         v1_ff[i]      <= v1_in[i];
         v2_ff[i]      <= v2_in[i];
         w_ff[i]       <= w_in[i];
         a_term_ff[i]  <= a_prod[i][ssi_pkg::SquareWidth-1:0];
         h_term_ff[i]  <= h_prod[i][ssi_pkg::CrossWidth-1:0];
         d0_term_ff[i] <= d0_prod[i][ssi_pkg::SquareWidth-1:0];
         d1_term_ff[i] <= d1_prod[i][ssi_pkg::SquareWidth-1:0];
      end
      r_ff      <= sphere_radius;
      rr_ff     <= r_ff * r_ff;
      len_sq_ff <= len_sq_in;
      neg_h_ff  <= neg_h_in;
      f0_ff     <= f0_in;
      f1_ff     <= f1_in;
   end

   assign dot.valid  = s3_valid_ff;
   assign dot.len_sq = len_sq_ff;
   assign dot.neg_h  = neg_h_ff;
   assign dot.f0     = f0_ff;
   assign dot.f1     = f1_ff;

endmodule

@@ hdl/ssi_decide.sv @@
module ssi_decide (
   input  logic             clock,
   input  logic             reset,
   input  ssi_pkg::dot_type dot,
   output logic             strobe,
   output logic             hit,
   output logic             degenerate
);

   // Stage 4: classify the endpoint signs and form the partial products.
   logic                          s4_valid_ff;
   logic                          degen_in, degen4_ff;
   logic                          sure_in, sure4_ff;
   logic                          disc_in, disc4_ff;
   logic [ssi_pkg::LenWidth-1:0]  nh_u, fc_u;
   logic [ssi_pkg::HalfWidth-1:0] nh_hi, nh_lo, a_hi, a_lo, f_hi, f_lo;
   ssi_pkg::part_type             hh_hh_ff, hh_hl_ff, hh_ll_ff;
   ssi_pkg::part_type             ac_hh_ff, ac_hl_ff, ac_lh_ff, ac_ll_ff;

   // Stage 5: assembled 68-bit products.
   logic              s5_valid_ff, degen5_ff, sure5_ff, disc5_ff;
   ssi_pkg::prod_type hh_in, ac_in, hh_ff, ac_ff;

   // Stage 6: result word.
   logic              strobe_ff, hit_ff, degen_ff;
   logic              hit_in;

   always_comb begin
      degen_in = (dot.len_sq == '0);
      sure_in  = (dot.f0 == '0) || (dot.f1 == '0)
               || (dot.f0[ssi_pkg::LenWidth] != dot.f1[ssi_pkg::LenWidth]);
      disc_in  = (dot.f0 > 0) && (dot.f1 > 0) && !dot.neg_h[ssi_pkg::LenWidth]
               && (dot.neg_h <= $signed({1'b0, dot.len_sq}));
      // Only meaningful when disc_in is set; then both values are non-negative.
      nh_u  = dot.neg_h[ssi_pkg::LenWidth-1:0];
      fc_u  = dot.f0[ssi_pkg::LenWidth-1:0];
      nh_hi = nh_u[ssi_pkg::LenWidth-1:ssi_pkg::HalfWidth];
      nh_lo = nh_u[ssi_pkg::HalfWidth-1:0];
      a_hi  = dot.len_sq[ssi_pkg::LenWidth-1:ssi_pkg::HalfWidth];
      a_lo  = dot.len_sq[ssi_pkg::HalfWidth-1:0];
      f_hi  = fc_u[ssi_pkg::LenWidth-1:ssi_pkg::HalfWidth];
      f_lo  = fc_u[ssi_pkg::HalfWidth-1:0];
   end

   always_comb begin
      hh_in = ({{ssi_pkg::PartWidth{1'b0}}, hh_hh_ff} << (2 * ssi_pkg::HalfWidth))
            + ({{ssi_pkg::PartWidth{1'b0}}, hh_hl_ff} << (ssi_pkg::HalfWidth + 1))
            + {{ssi_pkg::PartWidth{1'b0}}, hh_ll_ff};
      ac_in = ({{ssi_pkg::PartWidth{1'b0}}, ac_hh_ff} << (2 * ssi_pkg::HalfWidth))
            + ({{ssi_pkg::PartWidth{1'b0}}, ac_hl_ff} << ssi_pkg::HalfWidth)
            + ({{ssi_pkg::PartWidth{1'b0}}, ac_lh_ff} << ssi_pkg::HalfWidth)
            + {{ssi_pkg::PartWidth{1'b0}}, ac_ll_ff};
   end

   assign hit_in = !degen5_ff && (sure5_ff || (disc5_ff && (hh_ff >= ac_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         s4_valid_ff <= dot.valid;
         s5_valid_ff <= s4_valid_ff;
         strobe_ff   <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      degen4_ff <= degen_in;
      sure4_ff  <= sure_in;
      disc4_ff  <= disc_in;
      hh_hh_ff  <= nh_hi * nh_hi;
      hh_hl_ff  <= nh_hi * nh_lo;
      hh_ll_ff  <= nh_lo * nh_lo;
      ac_hh_ff  <= a_hi * f_hi;
      ac_hl_ff  <= a_hi * f_lo;
      ac_lh_ff  <= a_lo * f_hi;
      ac_ll_ff  <= a_lo * f_lo;
      degen5_ff <= degen4_ff;
      sure5_ff  <= sure4_ff;
      disc5_ff  <= disc4_ff;
      hh_ff     <= hh_in;
      ac_ff     <= ac_in;
      hit_ff    <= hit_in;
      degen_ff  <= degen5_ff;
   end

   assign strobe     = strobe_ff;
   assign hit        = hit_ff;
   assign degenerate = degen_ff;

endmodule
